### rtl/lper_pkg.sv
package lper_pkg;

  // Widths fixed by the field formats.
  localparam int NodeW   = 12;
  localparam int WeightW = 32;
  localparam int ScoreW  = 64;

  // Default sizes of the node table and the edge store.
  localparam int MaxNodesDef = 4096;
  localparam int MaxEdgesDef = 8192;

  // Register indexes on the configuration port (byte address bit 2).
  localparam logic CFG_NODE_COUNT  = 1'b0;
  localparam logic CFG_TARGET_NODE = 1'b1;

  // Saturation limits of a score.
  localparam logic signed [ScoreW-1:0] SCORE_MAX = {1'b0, {(ScoreW-1){1'b1}}};
  localparam logic signed [ScoreW-1:0] SCORE_MIN = {1'b1, {(ScoreW-1){1'b0}}};

  // One incoming edge word.
  typedef struct packed {
    logic [NodeW-1:0]          from_node;
    logic [NodeW-1:0]          to_node;
    logic signed [WeightW-1:0] edge_weight;
    logic                      last_edge;
  } in_word_t;

  // One result word.
  typedef struct packed {
    logic signed [ScoreW-1:0] best_score;
    logic                     target_reached;
    logic                     unbounded;
  } out_word_t;

  // One entry of the node table.
  typedef struct packed {
    logic                     reached;
    logic signed [ScoreW-1:0] score;
  } node_word_t;

  // Decision of the relaxation unit for the edge in flight.
  typedef struct packed {
    logic                     relax;
    logic signed [ScoreW-1:0] cand;
  } relax_res_t;

endpackage

### rtl/lper_relax.sv
module lper_relax
  import lper_pkg::*;
(
  input  logic                      clk,
  input  logic                      load,
  input  node_word_t                src_q,
  input  node_word_t                dst_q,
  input  logic signed [WeightW-1:0] weight,
  input  logic                      in_range,
  output relax_res_t                res
);

  logic signed [ScoreW:0]   sum;
  logic signed [ScoreW-1:0] sat;
  logic signed [ScoreW-1:0] cand_r;
  node_word_t               dst_r;
  logic                     ok_r;

  // Candidate score: source score plus weight, clamped to the 64-bit range.
  always_comb begin
    sum = (ScoreW+1)'($signed(src_q.score)) + (ScoreW+1)'(weight);
    if (sum[ScoreW] != sum[ScoreW-1]) begin
      sat = sum[ScoreW] ? SCORE_MIN : SCORE_MAX;
    end else begin
      sat = sum[ScoreW-1:0];
    end
  end

  // Hold the candidate and the destination entry for the compare cycle.
  always_ff @(posedge clk) begin
    if (load) begin
      cand_r <= sat;
      dst_r  <= dst_q;
      ok_r   <= in_range & src_q.reached;
    end
  end

  // In-range edge from a reached node relaxes if dst is new or cand better.
  assign res.relax = ok_r && (!dst_r.reached || ($signed(dst_r.score) < cand_r));
  assign res.cand  = cand_r;

endmodule

### rtl/longest_path_edge_relaxation.sv
// Longest-path edge relaxation, maximum score from node 1.
// Input channel (in_valid/in_ready/in_data): one edge word per handshake. Edges
// are stored in order; the word with last_edge set is stored too and starts the
// run. Edges load at one word per cycle while no run is pending or running.
// Result channel (out_valid/out_ready/out_data): one word per last edge with the
// best score at target_node, a reached flag and an unbounded flag.
// Configuration: APB-style port, node_count at byte address 0, target_node at 4.
// The run starts from idle once a last edge is pending, or when the clear ends.
// Each pass over the stored edges has a pass start step, then per edge an edge
// store read, two node table reads, the add, and the compare with write back.
// Up to node_count-1 passes run, then a check pass unless one ended unchanged;
// the target read and the result register close the run. After reset and after
// every result the node table is cleared, one entry per cycle, over all of its
// MAX_NODES entries. Edges of the next graph are taken meanwhile; a last edge
// waits for the clear to finish.
// The result sits in an output register: while the receiver stalls the block
// keeps loading the next graph, and only the following result waits for it.
module longest_path_edge_relaxation
  import lper_pkg::*;
#(
  parameter int MAX_NODES = MaxNodesDef,
  parameter int MAX_EDGES = MaxEdgesDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_word_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_word_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int NODE_AW = $clog2(MAX_NODES);
  localparam int EDGE_AW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int CNT_W   = $clog2(MAX_EDGES + 1);
  localparam int EW      = CNT_W + 1;
  localparam int EDGE_DW = 2 * NodeW + WeightW;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_PASS,
    S_EDGE_RD,
    S_NODE_RD,
    S_ADD,
    S_CMP,
    S_TGT_RD,
    S_RESULT
  } state_t;

  state_t               state_r;
  logic [NodeW-1:0]     node_count_r;
  logic [NodeW-1:0]     target_node_r;
  logic [CNT_W-1:0]     edge_cnt_r;
  logic [EDGE_AW-1:0]   edge_idx_r;
  logic [NODE_AW-1:0]   clr_idx_r;
  logic [NodeW-1:0]     pass_cnt_r;
  logic [NodeW-1:0]     pass_lim;
  logic                 run_pend_r;
  logic                 changed_r;
  logic                 any_r;
  logic                 check_r;
  logic                 unb_r;
  logic                 out_valid_r;
  out_word_t            out_data_r;

  logic [EDGE_DW-1:0]   edge_mem [MAX_EDGES];
  logic [EDGE_DW-1:0]   edge_q;
  node_word_t           node_mem [MAX_NODES];
  node_word_t           node_qa;
  node_word_t           node_qb;

  logic                 in_acc;
  logic                 cfg_wr;
  logic [NodeW-1:0]     e_src;
  logic [NodeW-1:0]     e_dst;
  logic signed [WeightW-1:0] e_wgt;
  logic                 src_ok;
  logic                 dst_ok;
  logic                 tgt_ok;
  logic [NODE_AW-1:0]   rd_addr_a;
  logic [NODE_AW-1:0]   rd_addr_b;
  logic                 nd_we;
  logic [NODE_AW-1:0]   nd_waddr;
  node_word_t           nd_wdata;
  logic                 last_idx;
  relax_res_t           rres;

  // Handshakes.
  assign in_ready  = ((state_r == S_CLEAR) || (state_r == S_IDLE)) && !run_pend_r;
  assign in_acc    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign pready    = 1'b1;
  assign cfg_wr    = psel && penable && pwrite;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r  <= NodeW'(1);
      target_node_r <= NodeW'(1);
    end else if (cfg_wr) begin
      case (paddr[2])
        CFG_NODE_COUNT:  node_count_r  <= pwdata[NodeW-1:0];
        CFG_TARGET_NODE: target_node_r <= pwdata[NodeW-1:0];
        default: ;
      endcase
    end
  end

  // Register readback.
  always_comb begin
    case (paddr[2])
      CFG_NODE_COUNT:  prdata = 32'(node_count_r);
      CFG_TARGET_NODE: prdata = 32'(target_node_r);
      default:         prdata = '0;
    endcase
  end

  // Edge store: written while loading, read at the edge under relaxation.
  always_ff @(posedge clk) begin
    if (in_acc && (32'(edge_cnt_r) < 32'(MAX_EDGES))) begin
      edge_mem[edge_cnt_r[EDGE_AW-1:0]] <= {in_data.from_node, in_data.to_node,
                                            in_data.edge_weight};
    end
    edge_q <= edge_mem[edge_idx_r];
  end

  assign e_src = edge_q[EDGE_DW-1 -: NodeW];
  assign e_dst = edge_q[WeightW +: NodeW];
  assign e_wgt = $signed(edge_q[WeightW-1:0]);

  assign src_ok = 32'(e_src) < 32'(MAX_NODES);
  assign dst_ok = 32'(e_dst) < 32'(MAX_NODES);
  assign tgt_ok = 32'(target_node_r) < 32'(MAX_NODES);

  // Read ports: A is the source in S_NODE_RD, else the target; B the destination.
  assign rd_addr_a = (state_r == S_NODE_RD) ? NODE_AW'(32'(e_src))
                                            : NODE_AW'(32'(target_node_r));
  assign rd_addr_b = NODE_AW'(32'(e_dst));

  // Node table write: clearing sweep, or the write back of a relaxed edge.
  always_comb begin
    nd_we    = 1'b0;
    nd_waddr = clr_idx_r;
    nd_wdata = '{reached: (clr_idx_r == NODE_AW'(1)), score: '0};
    if (state_r == S_CLEAR) begin
      nd_we = 1'b1;
    end else if ((state_r == S_CMP) && rres.relax && !check_r) begin
      nd_we    = 1'b1;
      nd_waddr = rd_addr_b;
      nd_wdata = '{reached: 1'b1, score: rres.cand};
    end
  end

  // Node table: one write port, two registered read ports.
  always_ff @(posedge clk) begin
    if (nd_we) begin
      node_mem[nd_waddr] <= nd_wdata;
    end
    node_qa <= node_mem[rd_addr_a];
    node_qb <= node_mem[rd_addr_b];
  end

  // Saturating add and compare for the edge in flight.
  lper_relax u_relax (
    .clk      (clk),
    .load     (state_r == S_ADD),
    .src_q    (node_qa),
    .dst_q    (node_qb),
    .weight   (e_wgt),
    .in_range (src_ok && dst_ok),
    .res      (rres)
  );

  assign pass_lim = (node_count_r > NodeW'(1)) ? (node_count_r - NodeW'(1)) : '0;
  assign last_idx = (EW'(edge_idx_r) + EW'(1)) == EW'(edge_cnt_r);

  // Sequencer: loading, pass control, edge steps and result.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_idx_r   <= '0;
      edge_cnt_r  <= '0;
      edge_idx_r  <= '0;
      pass_cnt_r  <= '0;
      run_pend_r  <= 1'b0;
      changed_r   <= 1'b0;
      any_r       <= 1'b0;
      check_r     <= 1'b0;
      unb_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // The result word is released at its handshake unless a new one replaces it.
      if (out_valid_r && out_ready && (state_r != S_RESULT)) begin
        out_valid_r <= 1'b0;
      end
      // Edges are counted up to the store size; later ones are dropped.
      if (in_acc) begin
        if (32'(edge_cnt_r) < 32'(MAX_EDGES)) begin
          edge_cnt_r <= edge_cnt_r + CNT_W'(1);
        end
        if (in_data.last_edge) begin
          run_pend_r <= 1'b1;
        end
      end
      case (state_r)
        S_CLEAR: begin
          clr_idx_r <= clr_idx_r + NODE_AW'(1);
          if (clr_idx_r == NODE_AW'(MAX_NODES - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (run_pend_r) begin
            changed_r  <= 1'b1;
            pass_cnt_r <= '0;
            state_r    <= S_PASS;
          end
        end
        S_PASS: begin
          edge_idx_r <= '0;
          any_r      <= 1'b0;
          if ((pass_cnt_r < pass_lim) && changed_r) begin
            check_r <= 1'b0;
            state_r <= S_EDGE_RD;
          end else if (changed_r) begin
            check_r <= 1'b1;
            state_r <= S_EDGE_RD;
          end else begin
            unb_r   <= 1'b0;
            state_r <= S_TGT_RD;
          end
        end
        S_EDGE_RD: state_r <= S_NODE_RD;
        S_NODE_RD: state_r <= S_ADD;
        S_ADD:     state_r <= S_CMP;
        S_CMP: begin
          if (rres.relax) begin
            any_r <= 1'b1;
          end
          if (last_idx) begin
            if (check_r) begin
              unb_r   <= any_r || rres.relax;
              state_r <= S_TGT_RD;
            end else begin
              changed_r  <= any_r || rres.relax;
              pass_cnt_r <= pass_cnt_r + NodeW'(1);
              state_r    <= S_PASS;
            end
          end else begin
            edge_idx_r <= edge_idx_r + EDGE_AW'(1);
            state_r    <= S_EDGE_RD;
          end
        end
        S_TGT_RD: state_r <= S_RESULT;
        S_RESULT: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r                <= 1'b1;
            out_data_r.target_reached  <= tgt_ok && node_qa.reached;
            out_data_r.best_score      <= (tgt_ok && node_qa.reached) ? node_qa.score
                                                                       : '0;
            out_data_r.unbounded       <= unb_r;
            run_pend_r                 <= 1'b0;
            edge_cnt_r                 <= '0;
            clr_idx_r                  <= '0;
            state_r                    <= S_CLEAR;
          end
        end
        default: state_r <= S_CLEAR;
      endcase
    end
  end

endmodule

### rtl/lper_checker.sv
module lper_checker
  import lper_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input in_word_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input out_word_t out_data
);

  logic pend_r;

  // Tracks a last edge that has been taken but not yet answered.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
    end else if (in_valid && in_ready && in_data.last_edge) begin
      pend_r <= 1'b1;
    end else if (out_valid && !$past(out_valid)) begin
      pend_r <= 1'b0;
    end
  end

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  // An unreached target reports a zero score.
  a_zero_score: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.target_reached |-> out_data.best_score == '0)
    else $error("unreached target with nonzero score");

  // A new result only follows a last edge.
  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> pend_r)
    else $error("result without a last edge");

  // Loading stops once a last edge is taken.
  a_run_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.last_edge |=> !in_ready)
    else $error("edge taken during a run");

endmodule

bind longest_path_edge_relaxation lper_checker u_lper_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

### tb/longest_path_edge_relaxation_checker.sv
`timescale 1ns / 1ps

module longest_path_edge_relaxation_checker
  import lper_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  in_word_t    in_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  out_word_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output int          fail_count,
  output int          results_pending
);

  // Register copies, as seen on the configuration port.
  logic [NodeW-1:0] node_count_q;
  logic [NodeW-1:0] target_node_q;

  // Edges of the graph being loaded.
  logic [NodeW-1:0]          graph_from   [MaxEdgesDef];
  logic [NodeW-1:0]          graph_to     [MaxEdgesDef];
  logic signed [WeightW-1:0] graph_weight [MaxEdgesDef];
  int                        graph_edges;

  // Best score and reached bit per node during a solve.
  logic signed [ScoreW-1:0] node_val [MaxNodesDef];
  bit                       node_hit [MaxNodesDef];

  // Results still owed by the block, oldest first.
  out_word_t expected_results [$];

  // Score plus edge weight, clamped to the signed 64-bit range.
  function automatic logic signed [ScoreW-1:0] add_clamped(
    input logic signed [ScoreW-1:0]  base,
    input logic signed [WeightW-1:0] gain
  );
    logic signed [ScoreW:0] sum;
    sum = base + gain;
    if (sum > SCORE_MAX) return SCORE_MAX;
    if (sum < SCORE_MIN) return SCORE_MIN;
    return sum[ScoreW-1:0];
  endfunction

  // Only node 1 is reached before the first pass.
  function automatic void clear_nodes();
    int n;
    for (n = 0; n < MaxNodesDef; n++) begin
      node_val[n] = '0;
      node_hit[n] = 1'b0;
    end
    node_hit[1] = 1'b1;
  endfunction

  // One in-order sweep over the stored edges. Without apply it only reports
  // whether some edge could still improve its destination.
  function automatic bit relax_sweep(input bit apply);
    bit                       any;
    int                       i;
    logic [NodeW-1:0]         src;
    logic [NodeW-1:0]         dst;
    logic signed [ScoreW-1:0] cand;
    any = 1'b0;
    for (i = 0; i < graph_edges; i++) begin
      src = graph_from[i];
      dst = graph_to[i];
      if (node_hit[src]) begin
        cand = add_clamped(node_val[src], graph_weight[i]);
        if (!node_hit[dst] || node_val[dst] < cand) begin
          if (!apply) return 1'b1;
          any = 1'b1;
          node_val[dst] = cand;
          node_hit[dst] = 1'b1;
        end
      end
    end
    return any;
  endfunction

  // Bounded Bellman-Ford for the maximum score, then the cycle check sweep.
  function automatic out_word_t solve_longest_path();
    out_word_t res;
    int        rounds;
    int        r;
    bit        changed;
    clear_nodes();
    rounds = (node_count_q > 1) ? int'(node_count_q) - 1 : 0;
    changed = 1'b1;
    for (r = 0; r < rounds && changed; r++) changed = relax_sweep(1'b1);
    if (changed) changed = relax_sweep(1'b0);
    res.best_score = '0;
    res.target_reached = node_hit[target_node_q];
    if (res.target_reached) res.best_score = node_val[target_node_q];
    res.unbounded = changed;
    return res;
  endfunction

  // Watch the three ports at every rising edge, in order: register writes,
  // incoming edges, then outgoing results.
  always @(posedge clk) begin
    out_word_t want;
    if (!rst_n) begin
      node_count_q = 12'd1;
      target_node_q = 12'd1;
      graph_edges = 0;
      expected_results.delete();
      fail_count = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr[1:0] == 2'b00) begin
        if (paddr[2] == CFG_NODE_COUNT) node_count_q = pwdata[NodeW-1:0];
        else target_node_q = pwdata[NodeW-1:0];
      end

      // Edges past the end of the store are dropped, but a last mark still counts.
      if (in_valid && in_ready) begin
        if (graph_edges < MaxEdgesDef) begin
          graph_from[graph_edges] = in_data.from_node;
          graph_to[graph_edges] = in_data.to_node;
          graph_weight[graph_edges] = in_data.edge_weight;
          graph_edges++;
        end
        if (in_data.last_edge) begin
          expected_results.push_back(solve_longest_path());
          graph_edges = 0;
        end
      end

      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result word: best_score %0d target_reached %0b unbounded %0b",
                 out_data.best_score, out_data.target_reached, out_data.unbounded);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (out_data.best_score !== want.best_score) begin
            $error("best_score: expected %0d, got %0d", want.best_score,
                   out_data.best_score);
            fail_count++;
          end
          if (out_data.target_reached !== want.target_reached) begin
            $error("target_reached: expected %0b, got %0b", want.target_reached,
                   out_data.target_reached);
            fail_count++;
          end
          if (out_data.unbounded !== want.unbounded) begin
            $error("unbounded: expected %0b, got %0b", want.unbounded,
                   out_data.unbounded);
            fail_count++;
          end
        end
      end
    end
    results_pending = expected_results.size();
  end

endmodule

### tb/longest_path_edge_relaxation_tb.sv
`timescale 1ns / 1ps

module longest_path_edge_relaxation_tb;
  import lper_pkg::*;

  localparam int CycleLimit = 6_000_000;
  // The node table clear after each result sweeps one node per cycle.
  localparam int ClearWait = MaxNodesDef + 104;
  localparam int RandomEdges = 900;
  localparam logic [2:0] ADDR_NODE_COUNT = {CFG_NODE_COUNT, 2'b00};
  localparam logic [2:0] ADDR_TARGET_NODE = {CFG_TARGET_NODE, 2'b00};

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  in_word_t    in_data;
  logic        out_valid;
  logic        out_ready;
  out_word_t   out_data;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int fail_count;
  int results_pending;
  int cycle_count = 0;
  bit in_fire_q = 1'b0;

  always #5 clk = ~clk;

  longest_path_edge_relaxation dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  longest_path_edge_relaxation_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .pready         (pready),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .fail_count     (fail_count),
    .results_pending(results_pending)
  );

  // Edge word handshake as sampled at the rising edge, read back at the falling one.
  always @(posedge clk) begin
    in_fire_q <= in_valid && in_ready;
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic in_word_t edge_word(input int from, input int to, input int weight,
                                         input bit last);
    in_word_t word;
    word.from_node = from[NodeW-1:0];
    word.to_node = to[NodeW-1:0];
    word.edge_weight = weight;
    word.last_edge = last;
    return word;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance with
  // valid still high, so the next word can follow without a bubble.
  task automatic send_edge(input in_word_t word, input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= word;
    @(negedge clk);
    while (!in_fire_q) @(negedge clk);
  endtask

  // Drop valid, wait for every owed result, then let the node table clear finish.
  task automatic settle();
    in_valid <= 1'b0;
    while (results_pending != 0) @(negedge clk);
    repeat (ClearWait) @(negedge clk);
  endtask

  // Setup then access phase; upper data bits are random and must be ignored.
  task automatic write_reg(input logic [2:0] addr, input int value);
    logic [31:0] bus;
    bus = $urandom;
    bus[NodeW-1:0] = value[NodeW-1:0];
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= bus;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    while (!pready) @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Random graph over nodes 0..span, with a few edges anywhere in the node range.
  task automatic send_random_graph(input int n_edges, input int span);
    in_word_t word;
    int       k;
    int       r;
    int       small_w;
    bit       steady;
    steady = ($urandom_range(0, 3) == 0);
    for (k = 0; k < n_edges; k++) begin
      r = $urandom_range(0, 99);
      if (k == 0 && r < 60) word.from_node = 12'd1;
      else if (r < 90) word.from_node = NodeW'($urandom_range(0, span));
      else word.from_node = NodeW'($urandom_range(0, 4095));
      r = $urandom_range(0, 99);
      if (r < 90) word.to_node = NodeW'($urandom_range(0, span));
      else word.to_node = NodeW'($urandom_range(0, 4095));
      r = $urandom_range(0, 99);
      if (r < 55) begin
        small_w = $urandom_range(0, 40);
        word.edge_weight = small_w - 20;
      end else if (r < 85) begin
        word.edge_weight = $urandom;
      end else if (r < 92) begin
        word.edge_weight = 32'sh7FFF_FFFF;
      end else begin
        word.edge_weight = 32'sh8000_0000;
      end
      word.last_edge = (k == n_edges - 1);
      send_edge(word, steady ? 0 : rand_gap());
    end
  endtask

  // Receiver: long ready stretches mixed with stalls of varied length.
  initial begin : result_sink
    int r;
    out_ready = 1'b0;
    while (!rst_n) @(negedge clk);
    forever begin
      r = $urandom_range(0, 99);
      if (r < 40) begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 60)) @(negedge clk);
      end else begin
        out_ready <= 1'b0;
        if (r < 80) repeat ($urandom_range(1, 4)) @(negedge clk);
        else if (r < 96) repeat ($urandom_range(5, 20)) @(negedge clk);
        else repeat ($urandom_range(40, 120)) @(negedge clk);
      end
    end
  end

  initial begin : stimulus
    int phase;
    int edges_sent;
    int r;
    int count;
    int target;
    int span;
    int n;
    bit big;

    in_valid = 1'b0;
    in_data = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    rst_n = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings: no relaxation pass, so an edge out of node 1 is still
    // open in the check sweep.
    send_edge(edge_word(1, 2, 5, 1), 0);

    // Largest node count and target, extreme weights and nodes; no positive cycle.
    settle();
    write_reg(ADDR_NODE_COUNT, 4095);
    write_reg(ADDR_TARGET_NODE, 4095);
    send_edge(edge_word(1, 4095, 32'sh7FFF_FFFF, 0), 0);
    send_edge(edge_word(4095, 0, 32'sh8000_0000, 0), 1);
    send_edge(edge_word(0, 4095, -1, 0), 0);
    send_edge(edge_word(4095, 4095, 0, 0), 2);
    send_edge(edge_word(0, 1, 1, 1), 0);

    // Node count zero and node 0 as target, which is only reached through an edge.
    settle();
    write_reg(ADDR_NODE_COUNT, 0);
    write_reg(ADDR_TARGET_NODE, 0);
    send_edge(edge_word(1, 0, -7, 1), 0);

    // Positive cycle, unreachable source, zero self loop, and a choice of paths.
    settle();
    write_reg(ADDR_NODE_COUNT, 4);
    write_reg(ADDR_TARGET_NODE, 3);
    send_edge(edge_word(1, 2, 3, 0), 0);
    send_edge(edge_word(2, 3, 4, 0), 0);
    send_edge(edge_word(3, 2, 1, 1), 0);
    send_edge(edge_word(5, 3, 9, 1), 3);
    send_edge(edge_word(1, 1, 0, 1), 0);
    send_edge(edge_word(1, 3, -100, 0), 0);
    send_edge(edge_word(1, 2, 50, 0), 0);
    send_edge(edge_word(2, 3, -200, 1), 1);

    // Random phases, each with its own register settings; one uses a large
    // node count with tiny graphs.
    phase = 0;
    edges_sent = 0;
    while (edges_sent < RandomEdges) begin
      settle();
      big = (phase == 2);
      r = $urandom_range(0, 99);
      if (big) count = $urandom_range(1000, 4095);
      else if (r < 10) count = 0;
      else if (r < 20) count = 1;
      else count = $urandom_range(2, 10);
      span = big ? 6 : (count < 3 ? 3 : count + 1);
      r = $urandom_range(0, 99);
      target = (r < 85) ? $urandom_range(0, span) : $urandom_range(0, 4095);
      if ($urandom_range(0, 1)) begin
        write_reg(ADDR_NODE_COUNT, count);
        write_reg(ADDR_TARGET_NODE, target);
      end else begin
        write_reg(ADDR_TARGET_NODE, target);
        write_reg(ADDR_NODE_COUNT, count);
      end
      repeat (big ? 2 : $urandom_range(6, 10)) begin
        n = big ? $urandom_range(1, 3) : $urandom_range(1, 16);
        send_random_graph(n, span);
        edges_sent += n;
      end
      phase++;
    end

    // Drain, then watch a little longer for stray results.
    in_valid <= 1'b0;
    while (results_pending != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (fail_count == 0 && results_pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### longest_path_edge_relaxation.f
rtl/lper_pkg.sv
rtl/lper_relax.sv
rtl/longest_path_edge_relaxation.sv
rtl/lper_checker.sv
tb/longest_path_edge_relaxation_checker.sv
tb/longest_path_edge_relaxation_tb.sv
